// ===== src/crpm_pkg.sv =====
// Shared types, constants and the pattern judge function for the chat
// response pattern matcher. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crpm_pkg;

  localparam int PATTERN_SLOTS  = 10;
  localparam int PATTERN_LENGTH = 16;
  localparam int BUFFER_DEPTH   = 128;

  localparam int CMD_W  = 3;
  localparam int SLOTF_W = 4;
  localparam int POSF_W = 4;
  localparam int CHAR_W = 8;
  localparam int STAT_W = 3;
  localparam int IDX_W  = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int CNT_W  = 4;
  localparam int TIME_W = 24;

  localparam int PS_DEPTH = PATTERN_SLOTS * PATTERN_LENGTH;
  localparam int PS_AW    = $clog2(PS_DEPTH);
  localparam int BUF_AW   = $clog2(BUFFER_DEPTH);
  localparam int MAT_W    = $clog2(BUFFER_DEPTH + 2);
  localparam int POS_W    = $clog2(PATTERN_LENGTH + 4);
  localparam int SLOT_W   = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
  localparam int SLOTC_W  = $clog2(PATTERN_SLOTS + 2);

  localparam logic [TIME_W-1:0] TICK_UNITS = TIME_W'(100);

  // commands
  localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RXCHAR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ABORT  = 3'd4;

  // result status
  localparam logic [STAT_W-1:0] STAT_WAITING  = 3'd0;
  localparam logic [STAT_W-1:0] STAT_MATCHED  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_TIMEOUT  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_ABORTED  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 3'd4;
  localparam logic [STAT_W-1:0] STAT_ACCEPTED = 3'd5;
  localparam logic [STAT_W-1:0] STAT_NOTRUN   = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PCOUNT  = 1'd1;

  // characters
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ETX    = 8'h03;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [SLOTF_W-1:0] pattern_slot;
    logic [POSF_W-1:0]  char_position;
    logic [CHAR_W-1:0]  char_value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  match_index;
  } out_item_t;

  typedef enum logic [2:0] {
    PS_INIT    = 3'd0,
    PS_MATCH   = 3'd1,
    PS_NEXT    = 3'd2,
    PS_MULT    = 3'd3,
    PS_SKIPPAT = 3'd4,
    PS_SKIPSRC = 3'd5,
    PS_OK      = 3'd6,
    PS_FAIL    = 3'd7
  } ps_t;

  typedef struct packed {
    ps_t  st;
    logic pat_inc;
  } judge_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SLOT,
    ST_CARET,
    ST_BPREV,
    ST_BCUR,
    ST_BNEXT,
    ST_SWINIT,
    ST_SWEEP,
    ST_JUDGE
  } ctl_state_t;

  typedef struct packed {
    logic              take;
    logic              post;
    logic [STAT_W-1:0] post_status;
    logic              do_load;
    logic              do_start;
    logic              do_append;
    logic              do_tick;
    logic              clr_run;
    logic              slot_first;
    logic              slot_load;
    logic              caret_cap;
    logic              bprev;
    logic              bcur;
    logic              bnext;
    logic              swinit;
    logic              sweep_step;
    logic              sweep_hold;
    logic              judge_apply;
    logic              slot_next;
  } crpm_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             running;
    logic             ch_etx;
    logic             ch_nul;
    logic             buf_full;
    logic             time_zero;
    logic             no_pattern;
    logic             slot_last;
    logic             sweep_done;
    logic             jr_match;
    logic             jr_end;
  } crpm_sts_t;

  function automatic logic [PS_AW-1:0] pat_addr(input logic [SLOT_W-1:0] slot,
                                                input logic [POS_W-1:0] pos);
    int a;
    a = int'(slot) * PATTERN_LENGTH + int'(pos);
    return PS_AW'(a);
  endfunction

  // One judge step at pattern position p against buffer char cs.
  // g1/g2: whether the judge at p+1 / p+2 ends in match or ok.
  function automatic judge_res_t judge_fn(input logic pos_nz,
                                          input logic [CHAR_W-1:0] pm1,
                                          input logic [CHAR_W-1:0] p0,
                                          input logic [CHAR_W-1:0] p1,
                                          input logic [CHAR_W-1:0] cs,
                                          input logic prev_cr,
                                          input logic snext_zero,
                                          input logic g1,
                                          input logic g2);
    judge_res_t r;
    logic mult;
    logic [CHAR_W-1:0] cp;
    mult = pos_nz && (p0 == CH_STAR || p0 == CH_PLUS);
    cp = mult ? pm1 : p0;
    r.st = mult ? PS_MULT : PS_MATCH;
    r.pat_inc = 1'b0;
    if (cp == CH_NUL) begin
      r.st = PS_OK;
    end else if (cs == CH_NUL) begin
      r.st = PS_FAIL;
    end else if (cp == CH_BSLASH) begin
      if (cs == p1) r.pat_inc = 1'b1;
      else r.st = PS_NEXT;
    end else if (mult && g1) begin
      r.st = PS_SKIPPAT;
    end else if (cp == CH_DOLLAR) begin
      if (cs == CH_CR) begin
        if (!prev_cr) begin
          if (p1 == CH_NUL && snext_zero) r.st = PS_OK;
          else r.st = PS_SKIPSRC;
        end
      end else if (cs != CH_LF) begin
        r.st = prev_cr ? PS_SKIPPAT : PS_NEXT;
      end
    end else if (cs == cp) begin
      r.st = r.st;
    end else if (p1 == CH_STAR) begin
      if (cp != CH_DOT || g2) begin
        r.pat_inc = 1'b1;
        r.st = PS_SKIPPAT;
      end
    end else if (cp != CH_DOT) begin
      r.st = PS_NEXT;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/crpm_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module crpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== src/crpm_ctrl.sv =====
// Controller state machine of the chat response pattern matcher.
// Depends on crpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crpm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire crpm_pkg::crpm_sts_t sts,
  output crpm_pkg::crpm_cmd_t    cmd
);

  crpm_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= crpm_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != crpm_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      crpm_pkg::ST_IDLE: begin
        if (start) state_nxt = crpm_pkg::ST_DECODE;
      end
      crpm_pkg::ST_DECODE: begin
        state_nxt = crpm_pkg::ST_IDLE;
        if (sts.command == crpm_pkg::CMD_RXCHAR && sts.running && !sts.ch_etx &&
            !sts.ch_nul && !sts.buf_full && !sts.no_pattern)
          state_nxt = crpm_pkg::ST_SLOT;
      end
      crpm_pkg::ST_SLOT:   state_nxt = crpm_pkg::ST_CARET;
      crpm_pkg::ST_CARET:  state_nxt = crpm_pkg::ST_BPREV;
      crpm_pkg::ST_BPREV:  state_nxt = crpm_pkg::ST_BCUR;
      crpm_pkg::ST_BCUR:   state_nxt = crpm_pkg::ST_BNEXT;
      crpm_pkg::ST_BNEXT:  state_nxt = crpm_pkg::ST_SWINIT;
      crpm_pkg::ST_SWINIT: state_nxt = crpm_pkg::ST_SWEEP;
      crpm_pkg::ST_SWEEP: begin
        if (sts.sweep_done) state_nxt = crpm_pkg::ST_JUDGE;
      end
      crpm_pkg::ST_JUDGE: begin
        priority if (sts.jr_match) state_nxt = crpm_pkg::ST_IDLE;
        else if (sts.jr_end) state_nxt = sts.slot_last ? crpm_pkg::ST_IDLE
                                                       : crpm_pkg::ST_SLOT;
        else state_nxt = crpm_pkg::ST_BPREV;
      end
      default: state_nxt = crpm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    unique case (state_r)
      crpm_pkg::ST_IDLE: cmd.take = start;
      crpm_pkg::ST_DECODE: begin
        cmd.post = 1'b1;
        unique case (sts.command)
          crpm_pkg::CMD_LOAD: begin
            cmd.do_load = 1'b1;
            cmd.post_status = crpm_pkg::STAT_ACCEPTED;
          end
          crpm_pkg::CMD_START: begin
            cmd.do_start = 1'b1;
            cmd.post_status = crpm_pkg::STAT_ACCEPTED;
          end
          crpm_pkg::CMD_RXCHAR: begin
            priority if (!sts.running) begin
              cmd.post_status = crpm_pkg::STAT_NOTRUN;
            end else if (sts.ch_etx) begin
              cmd.clr_run = 1'b1;
              cmd.post_status = crpm_pkg::STAT_ABORTED;
            end else if (sts.ch_nul) begin
              cmd.post_status = crpm_pkg::STAT_WAITING;
            end else if (sts.buf_full) begin
              cmd.clr_run = 1'b1;
              cmd.post_status = crpm_pkg::STAT_OVERFLOW;
            end else begin
              cmd.do_append = 1'b1;
              cmd.slot_first = 1'b1;
              cmd.post = sts.no_pattern;
              cmd.post_status = crpm_pkg::STAT_WAITING;
            end
          end
          crpm_pkg::CMD_TICK: begin
            priority if (!sts.running) begin
              cmd.post_status = crpm_pkg::STAT_NOTRUN;
            end else if (sts.time_zero) begin
              cmd.clr_run = 1'b1;
              cmd.post_status = crpm_pkg::STAT_TIMEOUT;
            end else begin
              cmd.do_tick = 1'b1;
              cmd.post_status = crpm_pkg::STAT_WAITING;
            end
          end
          crpm_pkg::CMD_ABORT: begin
            cmd.clr_run = sts.running;
            cmd.post_status = sts.running ? crpm_pkg::STAT_ABORTED
                                          : crpm_pkg::STAT_NOTRUN;
          end
          default: begin
            cmd.post_status = sts.running ? crpm_pkg::STAT_WAITING
                                          : crpm_pkg::STAT_NOTRUN;
          end
        endcase
      end
      crpm_pkg::ST_SLOT:   cmd.slot_load = 1'b1;
      crpm_pkg::ST_CARET:  cmd.caret_cap = 1'b1;
      crpm_pkg::ST_BPREV:  cmd.bprev = 1'b1;
      crpm_pkg::ST_BCUR:   cmd.bcur = 1'b1;
      crpm_pkg::ST_BNEXT:  cmd.bnext = 1'b1;
      crpm_pkg::ST_SWINIT: cmd.swinit = 1'b1;
      crpm_pkg::ST_SWEEP: begin
        cmd.sweep_hold = sts.sweep_done;
        cmd.sweep_step = !sts.sweep_done;
      end
      crpm_pkg::ST_JUDGE: begin
        cmd.judge_apply = 1'b1;
        priority if (sts.jr_match) begin
          cmd.post = 1'b1;
          cmd.clr_run = 1'b1;
          cmd.post_status = crpm_pkg::STAT_MATCHED;
        end else if (sts.jr_end) begin
          cmd.post = sts.slot_last;
          cmd.post_status = crpm_pkg::STAT_WAITING;
          cmd.slot_next = !sts.slot_last;
        end else begin
          cmd.post = 1'b0;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/crpm_dp.sv =====
// Datapath: pattern store, receive buffer, match contexts, timer, judge
// and result register. Depends on crpm_pkg and crpm_ram.
`timescale 1ns / 1ps
`default_nettype none

module crpm_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire crpm_pkg::in_item_t             in_item,
  input  wire logic                           cfg_we,
  input  wire logic [crpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [crpm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire crpm_pkg::crpm_cmd_t            cmd,
  output crpm_pkg::crpm_sts_t                 sts,
  output logic                                out_strobe,
  output crpm_pkg::out_item_t                 out_item
);

  localparam logic [crpm_pkg::POS_W-1:0] PL_P = crpm_pkg::POS_W'(crpm_pkg::PATTERN_LENGTH);
  localparam logic [crpm_pkg::MAT_W-1:0] DEPTH_P =
    crpm_pkg::MAT_W'(crpm_pkg::BUFFER_DEPTH);
  localparam logic [crpm_pkg::SLOTC_W-1:0] SLOTS_P =
    crpm_pkg::SLOTC_W'(crpm_pkg::PATTERN_SLOTS);

  // configuration
  logic [crpm_pkg::CFG_DATA_W-1:0] timeout_limit_r;
  logic [crpm_pkg::CNT_W-1:0]      pattern_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_limit_r <= '0;
      pattern_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crpm_pkg::REG_TIMEOUT: timeout_limit_r <= cfg_wdata;
        crpm_pkg::REG_PCOUNT:  pattern_count_r <= cfg_wdata[crpm_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  crpm_pkg::in_item_t item_r;
  always_ff @(posedge clk) begin
    if (cmd.take) item_r <= in_item;
  end

  // run state
  logic                        running_r;
  logic [crpm_pkg::TIME_W-1:0] time_r;
  logic [crpm_pkg::MAT_W-1:0]  len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      time_r    <= '0;
      len_r     <= '0;
    end else begin
      if (cmd.do_start) begin
        running_r <= 1'b1;
        time_r    <= crpm_pkg::TIME_W'(timeout_limit_r) * crpm_pkg::TICK_UNITS;
        len_r     <= '0;
      end else begin
        if (cmd.clr_run) running_r <= 1'b0;
        if (cmd.do_append) begin
          len_r <= len_r + 1'b1;
          if (time_r != '0) time_r <= time_r - 1'b1;
        end
        if (cmd.do_tick)
          time_r <= (time_r > crpm_pkg::TICK_UNITS) ? time_r - crpm_pkg::TICK_UNITS : '0;
      end
    end
  end

  // slot sequencing
  logic [crpm_pkg::SLOTC_W-1:0] cnt;
  logic [crpm_pkg::SLOT_W-1:0]  slot_r;

  assign cnt = (crpm_pkg::SLOTC_W'(pattern_count_r) < SLOTS_P) ?
               crpm_pkg::SLOTC_W'(pattern_count_r) : SLOTS_P;

  always_ff @(posedge clk) begin
    if (!rst_n) slot_r <= '0;
    else if (cmd.slot_first) slot_r <= '0;
    else if (cmd.slot_next) slot_r <= slot_r + 1'b1;
  end

  // per-slot contexts
  logic [crpm_pkg::POS_W-1:0] pat_a_r [crpm_pkg::PATTERN_SLOTS];
  logic [crpm_pkg::MAT_W-1:0] src_a_r [crpm_pkg::PATTERN_SLOTS];
  logic [crpm_pkg::MAT_W-1:0] mat_a_r [crpm_pkg::PATTERN_SLOTS];

  logic [crpm_pkg::POS_W-1:0] pat_r, pat_nxt;
  logic [crpm_pkg::MAT_W-1:0] src_r, src_nxt;
  logic [crpm_pkg::MAT_W-1:0] mat_r, mat_nxt;

  // memories
  logic                        p_we;
  logic [crpm_pkg::PS_AW-1:0]  p_waddr, p_raddr;
  logic [crpm_pkg::CHAR_W-1:0] p_rdata;
  logic                        b_we;
  logic [crpm_pkg::BUF_AW-1:0] b_raddr;
  logic [crpm_pkg::CHAR_W-1:0] b_rdata;

  assign p_we = cmd.do_load &&
                (int'(item_r.pattern_slot) < crpm_pkg::PATTERN_SLOTS) &&
                (int'(item_r.char_position) < crpm_pkg::PATTERN_LENGTH);
  assign p_waddr = crpm_pkg::pat_addr(crpm_pkg::SLOT_W'(item_r.pattern_slot),
                                      crpm_pkg::POS_W'(item_r.char_position));
  assign b_we = cmd.do_append;

  crpm_ram #(.WIDTH(crpm_pkg::CHAR_W), .DEPTH(crpm_pkg::PS_DEPTH)) u_pat_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (item_r.char_value),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  crpm_ram #(.WIDTH(crpm_pkg::CHAR_W), .DEPTH(crpm_pkg::BUFFER_DEPTH)) u_buf_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (len_r[crpm_pkg::BUF_AW-1:0]),
    .wdata (item_r.char_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // buffer reads at mat-1, mat, mat+1; out of range reads as zero
  logic [crpm_pkg::MAT_W-1:0] b_k;
  logic                       b_ok, b_ok_r;
  logic [crpm_pkg::CHAR_W-1:0] b_val;
  logic                       prev_cr_r, snz_r;
  logic [crpm_pkg::CHAR_W-1:0] cs_r;

  always_comb begin
    b_k  = mat_r;
    b_ok = 1'b0;
    if (cmd.bprev) begin
      b_k  = mat_r - 1'b1;
      b_ok = (mat_r != '0) && (b_k < len_r);
    end else if (cmd.bcur) begin
      b_k  = mat_r;
      b_ok = (mat_r < len_r);
    end else if (cmd.bnext) begin
      b_k  = mat_r + 1'b1;
      b_ok = (b_k < len_r);
    end
  end

  assign b_raddr = b_k[crpm_pkg::BUF_AW-1:0];
  assign b_val   = b_ok_r ? b_rdata : crpm_pkg::CH_NUL;

  always_ff @(posedge clk) begin
    b_ok_r <= b_ok;
    if (cmd.bcur)   prev_cr_r <= (b_val == crpm_pkg::CH_CR);
    if (cmd.bnext)  cs_r      <= b_val;
    if (cmd.swinit) snz_r     <= (b_val == crpm_pkg::CH_NUL);
  end

  // backward sweep over pattern positions computing nested judge results
  logic [crpm_pkg::POS_W-1:0]  q_r, q0;
  logic [crpm_pkg::CHAR_W-1:0] w0_r, w1_r, wm1_r, pm1;
  logic                        g1_r, g2_r, p_ok, p_ok_r, caret_r;
  logic [crpm_pkg::POS_W-1:0]  p_pos;
  crpm_pkg::judge_res_t        sw_res, top_res;
  logic                        sw_good;

  assign q0  = (pat_r > PL_P) ? pat_r : PL_P;
  assign pm1 = p_ok_r ? p_rdata : crpm_pkg::CH_NUL;

  always_comb begin
    p_pos = '0;
    p_ok  = 1'b0;
    if (cmd.slot_load) begin
      p_pos = '0;
      p_ok  = 1'b1;
    end else if (cmd.swinit) begin
      p_pos = q0 - 1'b1;
      p_ok  = (p_pos < PL_P);
    end else if (cmd.sweep_step) begin
      p_pos = q_r - 2'd2;
      p_ok  = (q_r >= 2) && (p_pos < PL_P);
    end
  end

  assign p_raddr = crpm_pkg::pat_addr(slot_r, p_ok ? p_pos : '0);

  assign sw_res = crpm_pkg::judge_fn(q_r != '0, pm1, w0_r, w1_r, cs_r, prev_cr_r,
                                     snz_r, g1_r, g2_r);
  assign sw_good = (sw_res.st == crpm_pkg::PS_MATCH) || (sw_res.st == crpm_pkg::PS_OK);

  always_ff @(posedge clk) begin
    p_ok_r <= p_ok;
    if (cmd.caret_cap) caret_r <= (p_rdata == crpm_pkg::CH_CARET);
    if (cmd.swinit) begin
      q_r  <= q0;
      w0_r <= crpm_pkg::CH_NUL;
      w1_r <= crpm_pkg::CH_NUL;
      g1_r <= 1'b1;
      g2_r <= 1'b1;
    end else if (cmd.sweep_step) begin
      q_r  <= q_r - 1'b1;
      w1_r <= w0_r;
      w0_r <= pm1;
      g2_r <= g1_r;
      g1_r <= sw_good;
    end
    if (cmd.sweep_hold) wm1_r <= pm1;
  end

  // top-level judge and context update
  logic jr_end;

  assign top_res = crpm_pkg::judge_fn(pat_r != '0, wm1_r, w0_r, w1_r, cs_r, prev_cr_r,
                                      snz_r, g1_r, g2_r);

  always_comb begin
    pat_nxt = pat_r + crpm_pkg::POS_W'(top_res.pat_inc);
    src_nxt = src_r;
    mat_nxt = mat_r;
    jr_end  = 1'b0;
    unique case (top_res.st)
      crpm_pkg::PS_MULT:    mat_nxt = mat_r + 1'b1;
      crpm_pkg::PS_MATCH: begin
        mat_nxt = mat_r + 1'b1;
        pat_nxt = pat_nxt + 1'b1;
      end
      crpm_pkg::PS_SKIPSRC: mat_nxt = mat_r + 1'b1;
      crpm_pkg::PS_SKIPPAT: pat_nxt = pat_nxt + 1'b1;
      crpm_pkg::PS_NEXT: begin
        if (caret_r) begin
          // anchored pattern gets exactly one retry at the buffer start
          if (pat_r == '0 && src_r == '0) begin
            pat_nxt = crpm_pkg::POS_W'(1);
            mat_nxt = '0;
          end else begin
            jr_end = 1'b1;
          end
        end else begin
          pat_nxt = '0;
          src_nxt = src_r + 1'b1;
          mat_nxt = src_r + 1'b1;
        end
      end
      crpm_pkg::PS_OK: pat_nxt = pat_r;
      crpm_pkg::PS_FAIL, crpm_pkg::PS_INIT: jr_end = 1'b1;
      default: jr_end = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.slot_load) begin
      pat_r <= pat_a_r[slot_r];
      src_r <= src_a_r[slot_r];
      mat_r <= mat_a_r[slot_r];
    end else if (cmd.judge_apply && !jr_end && top_res.st != crpm_pkg::PS_OK) begin
      pat_r <= pat_nxt;
      src_r <= src_nxt;
      mat_r <= mat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < crpm_pkg::PATTERN_SLOTS; i++) begin
        pat_a_r[i] <= '0;
        src_a_r[i] <= '0;
        mat_a_r[i] <= '0;
      end
    end else if (cmd.do_start) begin
      for (int i = 0; i < crpm_pkg::PATTERN_SLOTS; i++) begin
        pat_a_r[i] <= '0;
        src_a_r[i] <= '0;
        mat_a_r[i] <= '0;
      end
    end else if (cmd.judge_apply && jr_end) begin
      pat_a_r[slot_r] <= pat_r;
      src_a_r[slot_r] <= src_r;
      mat_a_r[slot_r] <= mat_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else out_strobe <= cmd.post;
    if (cmd.post) begin
      out_item.status      <= cmd.post_status;
      out_item.match_index <= (cmd.post_status == crpm_pkg::STAT_MATCHED) ?
                              crpm_pkg::IDX_W'(slot_r) : '0;
    end
  end

  assign sts.command    = item_r.command;
  assign sts.running    = running_r;
  assign sts.ch_etx     = (item_r.char_value == crpm_pkg::CH_ETX);
  assign sts.ch_nul     = (item_r.char_value == crpm_pkg::CH_NUL);
  assign sts.buf_full   = (len_r >= DEPTH_P);
  assign sts.time_zero  = (time_r == '0);
  assign sts.no_pattern = (cnt == '0);
  assign sts.slot_last  = ((crpm_pkg::SLOTC_W'(slot_r) + 1'b1) >= cnt);
  assign sts.sweep_done = (q_r == pat_r);
  assign sts.jr_match   = (top_res.st == crpm_pkg::PS_OK);
  assign sts.jr_end     = jr_end;

endmodule

`default_nettype wire

// ===== src/chat_response_pattern_matcher.sv =====
// Top level of the chat response pattern matcher: controller plus datapath.
// Depends on crpm_pkg, crpm_ctrl, crpm_dp.
//
//   channel  handshake            payload
//   in       start / busy         in_item  (command, slot, position, char)
//   out      out_strobe           out_item (status, match_index)
//   cfg      cfg_we               cfg_index, cfg_wdata
//
// Load, start, tick, abort and ignored chars are decoded and answered through the result register.
// An appended char runs, per pattern scanned, slot load and caret capture, and per judge step
// three buffer reads, sweep init, a backward pattern RAM sweep at one read per cycle and the judge.
// Reset clears run state, contexts and configuration registers; the pattern RAM and buffer are not cleared.
// busy is high from transfer until the result strobe; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module chat_response_pattern_matcher (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire crpm_pkg::in_item_t              in_item,
  output logic                                 out_strobe,
  output crpm_pkg::out_item_t                  out_item,
  input  wire logic                            cfg_we,
  input  wire logic [crpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [crpm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  crpm_pkg::crpm_cmd_t cmd;
  crpm_pkg::crpm_sts_t sts;

  crpm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  crpm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire
